FILE: sv/polynomial_add_sub_merge_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial add/subtract merge block
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_SUB_MERGE_MACROS_SVH
`define POLYNOMIAL_ADD_SUB_MERGE_MACROS_SVH

// A condition that must hold at every clock edge.
`define PASM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger whose consequence must hold in the cycle after it.
`define PASM_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pasm_pkg.sv
// ----------------------------------------------------------------------------
// pasm_pkg
// Types and codes shared by the polynomial add/subtract merge block and its
// users: transaction payloads, stored term layout and register indexes.
// ----------------------------------------------------------------------------
package pasm_pkg;

    localparam int EXP_W   = 8;
    localparam int COEFF_W = 32;
    localparam int VARS_HW = 4;

    // Transaction kinds
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // Monomial order codes; the unused code behaves as lex
    localparam logic [1:0] ORDER_LEX     = 2'd0;
    localparam logic [1:0] ORDER_GRLEX   = 2'd1;
    localparam logic [1:0] ORDER_GREVLEX = 2'd2;

    // Configuration register indexes
    localparam logic REG_ORDER_MODE    = 1'b0;
    localparam logic REG_SUBTRACT_MODE = 1'b1;

    localparam logic signed [COEFF_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEFF_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [EXP_W-1:0]           exponent_0;
        logic [EXP_W-1:0]           exponent_1;
        logic [EXP_W-1:0]           exponent_2;
        logic [EXP_W-1:0]           exponent_3;
        logic signed [COEFF_W-1:0]  coefficient;
    } in_item_t;

    typedef struct packed {
        logic [EXP_W-1:0]           out_exponent_0;
        logic [EXP_W-1:0]           out_exponent_1;
        logic [EXP_W-1:0]           out_exponent_2;
        logic [EXP_W-1:0]           out_exponent_3;
        logic signed [COEFF_W-1:0]  out_coefficient;
        logic                       term_valid;
        logic                       capacity_overflow;
        logic                       last_term;
    } out_item_t;

    // One stored term: exponent[0] belongs to the most significant variable.
    typedef struct packed {
        logic [VARS_HW-1:0][EXP_W-1:0] exponent;
        logic signed [COEFF_W-1:0]     coefficient;
    } term_t;

endpackage

FILE: sv/polynomial_add_sub_merge.sv
// ----------------------------------------------------------------------------
// polynomial_add_sub_merge
// A load transaction is taken while idle; a new transaction is taken on the next cycle.
// A run does one S_READ, S_MERGE pass per step, waiting in S_MERGE on output stall;
// each step reads and compares one term of A, of B or both: at most nA + nB steps.
// Kept terms leave at most one per step, each held until the next is known.
// rst_n (asynchronous, active low) empties both lists, clears the overflow flag
// and loads order_mode = lex, subtract_mode = subtract; term memories keep data.
// ----------------------------------------------------------------------------
`include "polynomial_add_sub_merge_macros.svh"

module polynomial_add_sub_merge
    import pasm_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int NUM_VARS  = 4
) (
    input  logic      clk,
    input  logic      rst_n,

    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,

    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result,

    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_MERGE = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        CMP_A_FIRST = 2'd0,
        CMP_B_FIRST = 2'd1,
        CMP_EQUAL   = 2'd2
    } cmp_t;

    // Stored monomials have unused variables forced to zero, so all four
    // exponents can take part in every comparison.
    function automatic cmp_t order_cmp(logic [1:0] mode, term_t a, term_t b);
        logic [9:0] deg_a;
        logic [9:0] deg_b;
        cmp_t       lex_res;
        cmp_t       rev_res;
        cmp_t       res;
        deg_a = 10'(a.exponent[0]) + 10'(a.exponent[1])
              + 10'(a.exponent[2]) + 10'(a.exponent[3]);
        deg_b = 10'(b.exponent[0]) + 10'(b.exponent[1])
              + 10'(b.exponent[2]) + 10'(b.exponent[3]);
        lex_res = CMP_EQUAL;
        for (int i = VARS_HW - 1; i >= 0; i--)
        begin
            if (a.exponent[i] != b.exponent[i])
            begin
                lex_res = (a.exponent[i] > b.exponent[i]) ? CMP_A_FIRST : CMP_B_FIRST;
            end
        end
        rev_res = CMP_EQUAL;
        for (int i = 0; i < VARS_HW; i++)
        begin
            if (a.exponent[i] != b.exponent[i])
            begin
                rev_res = (a.exponent[i] < b.exponent[i]) ? CMP_A_FIRST : CMP_B_FIRST;
            end
        end
        if ((mode == ORDER_GRLEX) || (mode == ORDER_GREVLEX))
        begin
            if (deg_a != deg_b)
            begin
                res = (deg_a > deg_b) ? CMP_A_FIRST : CMP_B_FIRST;
            end
            else
            begin
                res = (mode == ORDER_GREVLEX) ? rev_res : lex_res;
            end
        end
        else
        begin
            res = lex_res;
        end
        return res;
    endfunction

    // Term memories
    term_t a_mem [MAX_TERMS];
    term_t b_mem [MAX_TERMS];

    state_t           state_reg,        state_next;
    logic [CNT_W-1:0] cnt_a_reg,        cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg,        cnt_b_next;
    logic [CNT_W-1:0] ia_reg,           ia_next;
    logic [CNT_W-1:0] ib_reg,           ib_next;
    logic             ovf_reg,          ovf_next;
    logic [1:0]       order_mode_reg,   order_mode_next;
    logic             sub_mode_reg,     sub_mode_next;
    term_t            pend_reg,         pend_next;
    logic             pend_valid_reg,   pend_valid_next;
    out_item_t        result_reg,       result_next;
    logic             result_valid_reg, result_valid_next;
    term_t            a_rd_reg;
    term_t            b_rd_reg;

    term_t                     load_term;
    logic                      wr_a;
    logic                      wr_b;
    logic                      a_has;
    logic                      b_has;
    logic                      done;
    cmp_t                      cmp;
    logic signed [COEFF_W:0]   op_a;
    logic signed [COEFF_W:0]   op_b;
    logic signed [COEFF_W:0]   sum_wide;
    logic signed [COEFF_W-1:0] sum_sat;
    term_t                     new_term;
    logic                      keep;
    logic                      out_free;
    logic                      need_out;
    logic                      step_go;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        load_term.exponent[0] = item.exponent_0;
        load_term.exponent[1] = item.exponent_1;
        load_term.exponent[2] = item.exponent_2;
        load_term.exponent[3] = item.exponent_3;
        for (int i = 0; i < VARS_HW; i++)
        begin
            if (i >= NUM_VARS)
            begin
                load_term.exponent[i] = '0;
            end
        end
        load_term.coefficient = item.coefficient;
    end

    assign wr_a = (state_reg == S_IDLE) && item_valid && (item.kind == KIND_LOAD_A)
                  && (cnt_a_reg != CNT_MAX);
    assign wr_b = (state_reg == S_IDLE) && item_valid && (item.kind == KIND_LOAD_B)
                  && (cnt_b_reg != CNT_MAX);

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[cnt_a_reg[IDX_W-1:0]] <= load_term;
        end
        if (wr_b)
        begin
            b_mem[cnt_b_reg[IDX_W-1:0]] <= load_term;
        end
        a_rd_reg <= a_mem[ia_reg[IDX_W-1:0]];
        b_rd_reg <= b_mem[ib_reg[IDX_W-1:0]];
    end

    // Shared compare and saturating add/subtract unit.
    always_comb
    begin
        a_has = (ia_reg < cnt_a_reg);
        b_has = (ib_reg < cnt_b_reg);
        done  = !a_has && !b_has;
        if (a_has && b_has)
        begin
            cmp = order_cmp(order_mode_reg, a_rd_reg, b_rd_reg);
        end
        else if (a_has)
        begin
            cmp = CMP_A_FIRST;
        end
        else
        begin
            cmp = CMP_B_FIRST;
        end
        op_a = (cmp != CMP_B_FIRST) ? (COEFF_W + 1)'(a_rd_reg.coefficient) : '0;
        op_b = (cmp != CMP_A_FIRST) ? (COEFF_W + 1)'(b_rd_reg.coefficient) : '0;
        sum_wide = sub_mode_reg ? (op_a - op_b) : (op_a + op_b);
        if (sum_wide[COEFF_W] != sum_wide[COEFF_W-1])
        begin
            sum_sat = sum_wide[COEFF_W] ? Q_MIN : Q_MAX;
        end
        else
        begin
            sum_sat = sum_wide[COEFF_W-1:0];
        end
        new_term.exponent    = (cmp != CMP_B_FIRST) ? a_rd_reg.exponent : b_rd_reg.exponent;
        new_term.coefficient = sum_sat;
        // Only a difference of like terms that cancels is dropped.
        keep     = !done && !(sub_mode_reg && (cmp == CMP_EQUAL) && (sum_sat == '0));
        out_free = !result_valid_reg || !result_stall;
        need_out = done || (keep && pend_valid_reg);
        step_go  = !need_out || out_free;
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_a_next        = cnt_a_reg;
        cnt_b_next        = cnt_b_reg;
        ia_next           = ia_reg;
        ib_next           = ib_reg;
        ovf_next          = ovf_reg;
        order_mode_next   = order_mode_reg;
        sub_mode_next     = sub_mode_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORDER_MODE:    order_mode_next = cfg_data;
                REG_SUBTRACT_MODE: sub_mode_next   = cfg_data[0];
                default:           order_mode_next = order_mode_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.kind)
                        KIND_LOAD_A:
                        begin
                            if (cnt_a_reg != CNT_MAX)
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_LOAD_B:
                        begin
                            if (cnt_b_reg != CNT_MAX)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_RUN:
                        begin
                            ia_next         = '0;
                            ib_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (step_go)
                begin
                    if (done)
                    begin
                        // The held term, or the zero marker, closes the run.
                        if (pend_valid_reg)
                        begin
                            result_next.out_exponent_0  = pend_reg.exponent[0];
                            result_next.out_exponent_1  = pend_reg.exponent[1];
                            result_next.out_exponent_2  = pend_reg.exponent[2];
                            result_next.out_exponent_3  = pend_reg.exponent[3];
                            result_next.out_coefficient = pend_reg.coefficient;
                            result_next.term_valid      = 1'b1;
                        end
                        else
                        begin
                            result_next.out_exponent_0  = '0;
                            result_next.out_exponent_1  = '0;
                            result_next.out_exponent_2  = '0;
                            result_next.out_exponent_3  = '0;
                            result_next.out_coefficient = '0;
                            result_next.term_valid      = 1'b0;
                        end
                        result_next.capacity_overflow = ovf_reg;
                        result_next.last_term         = 1'b1;
                        result_valid_next             = 1'b1;
                        pend_valid_next               = 1'b0;
                        cnt_a_next                    = '0;
                        cnt_b_next                    = '0;
                        ovf_next                      = 1'b0;
                        state_next                    = S_IDLE;
                    end
                    else
                    begin
                        // A kept term is held back until the next one shows
                        // whether it is the last of the run.
                        if (keep)
                        begin
                            if (pend_valid_reg)
                            begin
                                result_next.out_exponent_0    = pend_reg.exponent[0];
                                result_next.out_exponent_1    = pend_reg.exponent[1];
                                result_next.out_exponent_2    = pend_reg.exponent[2];
                                result_next.out_exponent_3    = pend_reg.exponent[3];
                                result_next.out_coefficient   = pend_reg.coefficient;
                                result_next.term_valid        = 1'b1;
                                result_next.capacity_overflow = ovf_reg;
                                result_next.last_term         = 1'b0;
                                result_valid_next             = 1'b1;
                            end
                            pend_next       = new_term;
                            pend_valid_next = 1'b1;
                        end
                        if (cmp != CMP_B_FIRST)
                        begin
                            ia_next = ia_reg + 1'b1;
                        end
                        if (cmp != CMP_A_FIRST)
                        begin
                            ib_next = ib_reg + 1'b1;
                        end
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_a_reg        <= '0;
            cnt_b_reg        <= '0;
            ia_reg           <= '0;
            ib_reg           <= '0;
            ovf_reg          <= 1'b0;
            order_mode_reg   <= ORDER_LEX;
            sub_mode_reg     <= 1'b1;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_a_reg        <= cnt_a_next;
            cnt_b_reg        <= cnt_b_next;
            ia_reg           <= ia_next;
            ib_reg           <= ib_next;
            ovf_reg          <= ovf_next;
            order_mode_reg   <= order_mode_next;
            sub_mode_reg     <= sub_mode_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    `PASM_ASSERT_ALWAYS(a_cnt_bound,
        (cnt_a_reg <= CNT_MAX) && (cnt_b_reg <= CNT_MAX),
        "list count beyond capacity")
    `PASM_ASSERT_ALWAYS(a_ptr_bound,
        (state_reg == S_IDLE) || ((ia_reg <= cnt_a_reg) && (ib_reg <= cnt_b_reg)),
        "merge pointer passed its list")
    `PASM_ASSERT_ALWAYS(a_pend_idle,
        (state_reg != S_IDLE) || !pend_valid_reg,
        "held term left over after a run")
    `PASM_ASSERT_NEXT(a_run_close,
        (state_reg == S_MERGE) && done && out_free,
        result_valid_reg && result_reg.last_term && (cnt_a_reg == '0)
            && (cnt_b_reg == '0) && !ovf_reg,
        "run did not close with a last transaction")

endmodule
